// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define DSTM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// clocked implication, off while reset is held
`define DSTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/dstm_pkg.sv =====
`default_nettype none

package dstm_pkg;

    localparam int STAMP_W  = 63;
    localparam int TAG_W    = 16;
    localparam int EVENT_W  = 2;
    localparam int TOL_W    = 32;
    localparam int LIMIT_W  = 5;
    localparam int SUM_W    = STAMP_W + 1;
    localparam int ENTRY_W  = STAMP_W + TAG_W;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 32'd2000000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = EVENT_W;
    localparam int M_PAD_W   = M_TDATA_W - STAMP_W - 2 * TAG_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOLERANCE   = 1'b0,
        REG_QUEUE_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_PAIR   = 2'd0,
        EV_DISC_A = 2'd1,
        EV_DISC_B = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        SRC_EVICT = 2'd0,
        SRC_PAIR  = 2'd1,
        SRC_DISA  = 2'd2,
        SRC_DISB  = 2'd3
    } push_src_t;

    typedef struct packed {
        logic      take_in;
        logic      wr_new;
        logic      rd_a_head;
        logic      rd_b_head;
        logic      pop_a_head;
        logic      pop_b_head;
        logic      capture_heads;
        logic      scan_clear;
        logic      scan_run;
        logic      push;
        push_src_t src;
        logic      flush;
        logic      shift_init;
        logic      shift_rd;
        logic      shift_wr;
        logic      dec_b;
    } cmd_t;

    typedef struct packed {
        logic kind_b;
        logic full_k;
        logic over_k;
        logic both_nonempty;
        logic scan_done;
        logic match;
        logic a_old;
        logic b_old;
        logic best_zero;
        logic shift_more;
        logic emit_ok;
        logic pend_v;
    } status_t;

endpackage

`default_nettype wire

// ===== design/dstm_ram.sv =====
`default_nettype none

module dstm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/dstm_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module dstm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire dstm_pkg::status_t status,
    output      dstm_pkg::cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHK    = 11'b000_0000_0010,
        S_WRITE  = 11'b000_0000_0100,
        S_LOOP   = 11'b000_0000_1000,
        S_HEAD   = 11'b000_0001_0000,
        S_SCAN   = 11'b000_0010_0000,
        S_DECIDE = 11'b000_0100_0000,
        S_PUSH   = 11'b000_1000_0000,
        S_SHRD   = 11'b001_0000_0000,
        S_SHWR   = 11'b010_0000_0000,
        S_FLUSH  = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic                wrote_reg, wrote_next;
    dstm_pkg::push_src_t src_reg, src_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wrote_reg <= 1'b0;
            src_reg   <= dstm_pkg::SRC_EVICT;
        end else begin
            state_reg <= state_next;
            wrote_reg <= wrote_next;
            src_reg   <= src_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        wrote_next = wrote_reg;
        src_next   = src_reg;
        cmd        = '0;
        cmd.src    = src_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_in = 1'b1;
                    wrote_next  = 1'b0;
                    state_next  = S_CHK;
                end
            end
            // before the append: evict if full; after it: evict while over the limit
            S_CHK: begin
                if (wrote_reg ? status.over_k : status.full_k) begin
                    cmd.rd_a_head = !status.kind_b;
                    cmd.rd_b_head = status.kind_b;
                    src_next      = dstm_pkg::SRC_EVICT;
                    state_next    = S_PUSH;
                end else if (!wrote_reg) begin
                    state_next = S_WRITE;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_WRITE: begin
                cmd.wr_new = 1'b1;
                wrote_next = 1'b1;
                state_next = S_CHK;
            end
            S_LOOP: begin
                if (status.both_nonempty) begin
                    cmd.rd_a_head  = 1'b1;
                    cmd.rd_b_head  = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_HEAD;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_HEAD: begin
                cmd.capture_heads = 1'b1;
                state_next        = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (status.scan_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (status.match) begin
                    src_next   = dstm_pkg::SRC_PAIR;
                    state_next = S_PUSH;
                end else if (status.a_old) begin
                    src_next   = dstm_pkg::SRC_DISA;
                    state_next = S_PUSH;
                end else if (status.b_old) begin
                    src_next   = dstm_pkg::SRC_DISB;
                    state_next = S_PUSH;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_PUSH: begin
                if (status.emit_ok) begin
                    cmd.push = 1'b1;
                    case (src_reg)
                        dstm_pkg::SRC_EVICT: begin
                            cmd.pop_a_head = !status.kind_b;
                            cmd.pop_b_head = status.kind_b;
                            state_next     = S_CHK;
                        end
                        dstm_pkg::SRC_PAIR: begin
                            cmd.pop_a_head = 1'b1;
                            if (status.best_zero) begin
                                cmd.pop_b_head = 1'b1;
                                state_next     = S_LOOP;
                            end else begin
                                cmd.shift_init = 1'b1;
                                state_next     = S_SHRD;
                            end
                        end
                        dstm_pkg::SRC_DISA: begin
                            cmd.pop_a_head = 1'b1;
                            state_next     = S_LOOP;
                        end
                        dstm_pkg::SRC_DISB: begin
                            cmd.pop_b_head = 1'b1;
                            state_next     = S_LOOP;
                        end
                        default: begin
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end
            // close the gap in queue b behind the matched entry
            S_SHRD: begin
                if (status.shift_more) begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHWR;
                end else begin
                    cmd.dec_b  = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_SHWR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHRD;
            end
            S_FLUSH: begin
                if (status.emit_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DSTM_ASSERT_IMP(a_idle_no_pending, state_reg == S_IDLE, !status.pend_v, "result held at idle")
    `DSTM_ASSERT_IMP(a_write_not_full, state_reg == S_WRITE, !status.full_k, "append to full queue")

endmodule

`default_nettype wire

// ===== design/dstm_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"

module dstm_datapath #(
    parameter int QUEUE_DEPTH = dstm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire dstm_pkg::cmd_t                   cmd,
    output      dstm_pkg::status_t                status,
    input  wire logic [dstm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [dstm_pkg::S_TUSER_W-1:0]   s_tuser,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [dstm_pkg::M_TDATA_W-1:0]   m_tdata,
    output      logic [dstm_pkg::M_TUSER_W-1:0]   m_tuser,
    output      logic                             m_tlast,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [dstm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dstm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = dstm_pkg::STAMP_W;
    localparam int TW = dstm_pkg::TAG_W;
    localparam int EW = dstm_pkg::ENTRY_W;

    typedef logic [dstm_pkg::SUM_W-1:0] sum_t;

    // physical slot of a logical queue position (ring buffer)
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] head);
        return (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
    endfunction

    function automatic logic [SW-1:0] absdiff(input logic [SW-1:0] x,
                                              input logic [SW-1:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    // configuration
    logic [dstm_pkg::TOL_W-1:0]   tol_reg;
    logic [dstm_pkg::LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]                lim;

    // arriving frame
    logic          kind_reg;
    logic [SW-1:0] in_stamp_reg;
    logic [TW-1:0] in_tag_reg;

    // queue pointers
    logic [AW-1:0] a_head_reg, b_head_reg;
    logic [CW-1:0] a_cnt_reg, b_cnt_reg;

    // loop pass heads
    logic [SW-1:0] fa_reg, fb_reg;
    logic [TW-1:0] fa_tag_reg, fb_tag_reg;

    // scan pipeline
    logic [CW-1:0] scan_idx_reg;
    logic          s1_v_reg, s2_v_reg;
    logic [AW-1:0] s1_idx_reg, s2_idx_reg;
    logic [SW-1:0] s2_d_reg, s2_stamp_reg;
    logic [TW-1:0] s2_tag_reg;
    logic [SW-1:0] best_d_reg, best_stamp_reg;
    logic [TW-1:0] best_tag_reg;
    logic [AW-1:0] best_idx_reg;
    logic [CW-1:0] shift_idx_reg;

    // pending and output results
    logic                 pend_v_reg;
    dstm_pkg::event_t     pend_ev_reg, m_ev_reg;
    logic [TW-1:0]        pend_atag_reg, pend_btag_reg, m_atag_reg, m_btag_reg;
    logic [SW-1:0]        pend_stamp_reg, m_stamp_reg;
    logic                 m_valid_reg, m_last_reg;

    // memories
    logic          a_we, a_re, b_we, b_re;
    logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [EW-1:0] a_wdata, a_rdata, b_wdata, b_rdata;
    logic [SW-1:0] a_rd_stamp, b_rd_stamp;
    logic [TW-1:0] a_rd_tag, b_rd_tag;

    logic          scan_rd;
    logic [CW-1:0] shift_src;
    logic          out_free, move;
    logic [CW-1:0] cnt_k;

    dstm_pkg::event_t new_ev;
    logic [TW-1:0]    new_atag, new_btag;
    logic [SW-1:0]    new_stamp;

    assign a_rd_stamp = a_rdata[SW-1:0];
    assign a_rd_tag   = a_rdata[EW-1:SW];
    assign b_rd_stamp = b_rdata[SW-1:0];
    assign b_rd_tag   = b_rdata[EW-1:SW];

    always_comb begin
        if (limit_reg == '0) begin
            lim = CW'(1);
        end else if (int'(limit_reg) > QUEUE_DEPTH) begin
            lim = CW'(QUEUE_DEPTH);
        end else begin
            lim = CW'(limit_reg);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg   <= dstm_pkg::TOL_RESET;
            limit_reg <= dstm_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            case (dstm_pkg::cfg_reg_t'(cfg_index))
                dstm_pkg::REG_TOLERANCE:   tol_reg   <= cfg_data;
                dstm_pkg::REG_QUEUE_LIMIT: limit_reg <= cfg_data[dstm_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            kind_reg     <= s_tuser[0];
            in_stamp_reg <= s_tdata[SW-1:0];
            in_tag_reg   <= s_tdata[EW-1:SW];
        end
        if (cmd.capture_heads) begin
            fa_reg     <= a_rd_stamp;
            fa_tag_reg <= a_rd_tag;
            fb_reg     <= b_rd_stamp;
            fb_tag_reg <= b_rd_tag;
        end
    end

    // memory ports
    assign scan_rd   = cmd.scan_run && (scan_idx_reg < b_cnt_reg);
    assign shift_src = shift_idx_reg + CW'(1);

    assign a_re    = cmd.rd_a_head;
    assign a_raddr = a_head_reg;
    assign a_we    = cmd.wr_new && !kind_reg;
    assign a_waddr = phys(a_head_reg, a_cnt_reg);
    assign a_wdata = {in_tag_reg, in_stamp_reg};

    assign b_re    = cmd.rd_b_head || scan_rd || cmd.shift_rd;
    assign b_raddr = cmd.shift_rd ? phys(b_head_reg, shift_src) :
                     scan_rd      ? phys(b_head_reg, scan_idx_reg) : b_head_reg;
    assign b_we    = (cmd.wr_new && kind_reg) || cmd.shift_wr;
    assign b_waddr = cmd.shift_wr ? phys(b_head_reg, shift_idx_reg) :
                                    phys(b_head_reg, b_cnt_reg);
    assign b_wdata = cmd.shift_wr ? b_rdata : {in_tag_reg, in_stamp_reg};

    dstm_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dstm_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_head_reg <= '0;
            a_cnt_reg  <= '0;
            b_head_reg <= '0;
            b_cnt_reg  <= '0;
        end else begin
            if (cmd.wr_new && !kind_reg) begin
                a_cnt_reg <= a_cnt_reg + CW'(1);
            end else if (cmd.pop_a_head) begin
                a_head_reg <= head_inc(a_head_reg);
                a_cnt_reg  <= a_cnt_reg - CW'(1);
            end
            if (cmd.wr_new && kind_reg) begin
                b_cnt_reg <= b_cnt_reg + CW'(1);
            end else if (cmd.pop_b_head) begin
                b_head_reg <= head_inc(b_head_reg);
                b_cnt_reg  <= b_cnt_reg - CW'(1);
            end else if (cmd.dec_b) begin
                b_cnt_reg <= b_cnt_reg - CW'(1);
            end
        end
    end

    // scan over queue b: read, difference, compare (earliest wins a tie)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
        end else begin
            if (cmd.scan_clear) begin
                scan_idx_reg <= '0;
            end else if (scan_rd) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            s1_v_reg <= scan_rd;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_rd) begin
            s1_idx_reg <= scan_idx_reg[AW-1:0];
        end
        if (s1_v_reg) begin
            s2_idx_reg   <= s1_idx_reg;
            s2_d_reg     <= absdiff(b_rd_stamp, fa_reg);
            s2_stamp_reg <= b_rd_stamp;
            s2_tag_reg   <= b_rd_tag;
        end
        if (s2_v_reg && (s2_idx_reg == '0 || s2_d_reg < best_d_reg)) begin
            best_idx_reg   <= s2_idx_reg;
            best_d_reg     <= s2_d_reg;
            best_stamp_reg <= s2_stamp_reg;
            best_tag_reg   <= s2_tag_reg;
        end
        if (cmd.shift_init) begin
            shift_idx_reg <= CW'(best_idx_reg);
        end else if (cmd.shift_wr) begin
            shift_idx_reg <= shift_src;
        end
    end

    // result selection
    always_comb begin
        new_ev    = dstm_pkg::EV_PAIR;
        new_atag  = '0;
        new_btag  = '0;
        new_stamp = '0;
        case (cmd.src)
            dstm_pkg::SRC_EVICT: begin
                if (kind_reg) begin
                    new_ev    = dstm_pkg::EV_DISC_B;
                    new_btag  = b_rd_tag;
                    new_stamp = b_rd_stamp;
                end else begin
                    new_ev    = dstm_pkg::EV_DISC_A;
                    new_atag  = a_rd_tag;
                    new_stamp = a_rd_stamp;
                end
            end
            dstm_pkg::SRC_PAIR: begin
                new_ev    = dstm_pkg::EV_PAIR;
                new_atag  = fa_tag_reg;
                new_btag  = best_tag_reg;
                new_stamp = (fa_reg < best_stamp_reg) ? fa_reg : best_stamp_reg;
            end
            dstm_pkg::SRC_DISA: begin
                new_ev    = dstm_pkg::EV_DISC_A;
                new_atag  = fa_tag_reg;
                new_stamp = fa_reg;
            end
            dstm_pkg::SRC_DISB: begin
                new_ev    = dstm_pkg::EV_DISC_B;
                new_btag  = fb_tag_reg;
                new_stamp = fb_reg;
            end
            default: ;
        endcase
    end

    // one result is held back so the final one can carry last
    assign out_free = !m_valid_reg || m_tready;
    assign move     = (cmd.push || cmd.flush) && pend_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                pend_v_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_v_reg <= 1'b0;
            end
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_ev_reg    <= pend_ev_reg;
            m_atag_reg  <= pend_atag_reg;
            m_btag_reg  <= pend_btag_reg;
            m_stamp_reg <= pend_stamp_reg;
            m_last_reg  <= cmd.flush;
        end
        if (cmd.push) begin
            pend_ev_reg    <= new_ev;
            pend_atag_reg  <= new_atag;
            pend_btag_reg  <= new_btag;
            pend_stamp_reg <= new_stamp;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{dstm_pkg::M_PAD_W{1'b0}}, m_stamp_reg, m_btag_reg, m_atag_reg};
    assign m_tuser  = m_ev_reg;
    assign m_tlast  = m_last_reg;

    // status
    assign cnt_k = kind_reg ? b_cnt_reg : a_cnt_reg;

    always_comb begin
        status               = '0;
        status.kind_b        = kind_reg;
        status.full_k        = (cnt_k == CW'(QUEUE_DEPTH));
        status.over_k        = (cnt_k > lim);
        status.both_nonempty = (a_cnt_reg != '0) && (b_cnt_reg != '0);
        status.scan_done     = (scan_idx_reg == b_cnt_reg) && !s1_v_reg && !s2_v_reg;
        status.match         = (best_d_reg <= SW'(tol_reg));
        status.a_old         = (sum_t'(fa_reg) + sum_t'(tol_reg)) < sum_t'(fb_reg);
        status.b_old         = (sum_t'(fb_reg) + sum_t'(tol_reg)) < sum_t'(fa_reg);
        status.best_zero     = (best_idx_reg == '0);
        status.shift_more    = (shift_src < b_cnt_reg);
        status.emit_ok       = !pend_v_reg || out_free;
        status.pend_v        = pend_v_reg;
    end

    `DSTM_ASSERT(a_cnt_bound, (a_cnt_reg <= CW'(QUEUE_DEPTH)) && (b_cnt_reg <= CW'(QUEUE_DEPTH)), "queue count above depth")
    `DSTM_ASSERT_IMP(a_scan_no_write, s1_v_reg || s2_v_reg, !b_we, "queue b written during scan")
    `DSTM_ASSERT_IMP(a_push_room, cmd.push && pend_v_reg, out_free, "result overwritten")

endmodule

`default_nettype wire

// ===== design/dual_stream_timestamp_matcher.sv =====
// Pairs frames from two sources by timestamp. Each input transfer is one frame (tuser 0 for
// source A, 1 for source B) that is appended to its source queue, a ring buffer in a small
// memory; evictions for a full or over-limit queue come out first as discard results, then the
// block repeatedly takes the oldest A frame, scans queue B for the closest stamp and emits a
// pair, a discard, or stops. One item is handled at a time: s_tready is high only while the
// block waits for a frame. Each matching pass scans queue B through the single read port of the
// queue B memory, and the B entries behind a matched B entry are moved up one by one; a busy
// output stalls the block. The last result of an item carries tlast; an item that causes no
// result gives none. Configuration writes (index 0 tolerance_ns, index 1 queue_limit) are
// always accepted and must only be made while the block is idle. There is no memory clearing
// after reset.
`default_nettype none

module dual_stream_timestamp_matcher #(
    parameter int QUEUE_DEPTH = dstm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [dstm_pkg::S_TDATA_W-1:0]   s_tdata,   // stamp, cloud_tag, pad
    input  wire logic [dstm_pkg::S_TUSER_W-1:0]   s_tuser,   // kind
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [dstm_pkg::M_TDATA_W-1:0]   m_tdata,   // a_tag, b_tag, pair_stamp, pad
    output      logic [dstm_pkg::M_TUSER_W-1:0]   m_tuser,   // event_res
    output      logic                             m_tlast,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [dstm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dstm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dstm_pkg::cmd_t    cmd;
    dstm_pkg::status_t status;

    dstm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dstm_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== tb/dstm_match_checker.sv =====
`timescale 1ns / 100ps

module dstm_match_checker #(
    parameter int QUEUE_DEPTH = dstm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [dstm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [dstm_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [dstm_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [dstm_pkg::M_TUSER_W-1:0]   m_tuser,
    input  wire logic                             m_tlast,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [dstm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dstm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    frames_seen,
    output int                                    pairs_seen,
    output int                                    discards_seen
);
    import dstm_pkg::*;

    typedef struct packed {
        event_t             ev;
        logic [TAG_W-1:0]   a_tag;
        logic [TAG_W-1:0]   b_tag;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } match_result_t;

    match_result_t expected_q[$];

    // shadow copy of both source queues, oldest entry at index 0
    logic [STAMP_W-1:0] a_stamp_m[QUEUE_DEPTH];
    logic [TAG_W-1:0]   a_tag_m[QUEUE_DEPTH];
    logic [STAMP_W-1:0] b_stamp_m[QUEUE_DEPTH];
    logic [TAG_W-1:0]   b_tag_m[QUEUE_DEPTH];
    int                 a_cnt;
    int                 b_cnt;
    logic [TOL_W-1:0]   tol_m;
    logic [LIMIT_W-1:0] limit_m;

    function automatic logic [SUM_W-1:0] stamp_dist(logic [SUM_W-1:0] x, logic [SUM_W-1:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    function void add_result(event_t ev, logic [TAG_W-1:0] at, logic [TAG_W-1:0] bt,
                             logic [STAMP_W-1:0] st);
        match_result_t r;
        r.ev = ev;
        r.a_tag = at;
        r.b_tag = bt;
        r.stamp = st;
        r.last = 1'b0;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function void drop_a(int idx);
        for (int i = idx; i < a_cnt - 1; i++) begin
            a_stamp_m[i] = a_stamp_m[i+1];
            a_tag_m[i]   = a_tag_m[i+1];
        end
        a_cnt--;
    endfunction

    function void drop_b(int idx);
        for (int i = idx; i < b_cnt - 1; i++) begin
            b_stamp_m[i] = b_stamp_m[i+1];
            b_tag_m[i]   = b_tag_m[i+1];
        end
        b_cnt--;
    endfunction

    function void predict_frame(logic is_b, logic [STAMP_W-1:0] stamp, logic [TAG_W-1:0] tag);
        int                 first;
        int                 lim;
        int                 best;
        logic [SUM_W-1:0]   fa;
        logic [SUM_W-1:0]   fb;
        logic [SUM_W-1:0]   tol;
        logic [SUM_W-1:0]   d;
        logic [SUM_W-1:0]   best_d;
        logic [STAMP_W-1:0] bs;
        first = expected_q.size();
        tol = SUM_W'(tol_m);
        lim = int'(limit_m);
        if (lim < 1)
            lim = 1;
        if (lim > QUEUE_DEPTH)
            lim = QUEUE_DEPTH;

        if (is_b) begin
            if (b_cnt >= QUEUE_DEPTH) begin
                add_result(EV_DISC_B, '0, b_tag_m[0], b_stamp_m[0]);
                drop_b(0);
            end
            b_stamp_m[b_cnt] = stamp;
            b_tag_m[b_cnt] = tag;
            b_cnt++;
            while (b_cnt > lim) begin
                add_result(EV_DISC_B, '0, b_tag_m[0], b_stamp_m[0]);
                drop_b(0);
            end
        end else begin
            if (a_cnt >= QUEUE_DEPTH) begin
                add_result(EV_DISC_A, a_tag_m[0], '0, a_stamp_m[0]);
                drop_a(0);
            end
            a_stamp_m[a_cnt] = stamp;
            a_tag_m[a_cnt] = tag;
            a_cnt++;
            while (a_cnt > lim) begin
                add_result(EV_DISC_A, a_tag_m[0], '0, a_stamp_m[0]);
                drop_a(0);
            end
        end

        while (a_cnt > 0 && b_cnt > 0) begin
            fa = SUM_W'(a_stamp_m[0]);
            fb = SUM_W'(b_stamp_m[0]);
            best = 0;
            best_d = stamp_dist(fb, fa);
            // strict compare keeps the earliest entry on a tie
            for (int i = 1; i < b_cnt; i++) begin
                d = stamp_dist(SUM_W'(b_stamp_m[i]), fa);
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            if (best_d <= tol) begin
                bs = b_stamp_m[best];
                add_result(EV_PAIR, a_tag_m[0], b_tag_m[best],
                           (a_stamp_m[0] < bs) ? a_stamp_m[0] : bs);
                drop_a(0);
                drop_b(best);
            end else if (fa + tol < fb) begin
                add_result(EV_DISC_A, a_tag_m[0], '0, a_stamp_m[0]);
                drop_a(0);
            end else if (fb + tol < fa) begin
                add_result(EV_DISC_B, '0, b_tag_m[0], b_stamp_m[0]);
                drop_b(0);
            end else begin
                break;
            end
        end

        if (expected_q.size() > first)
            expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        fail_count++;
    endfunction

    function void check_result();
        match_result_t want;
        match_result_t got;
        got.ev    = event_t'(m_tuser);
        got.a_tag = m_tdata[TAG_W-1:0];
        got.b_tag = m_tdata[2*TAG_W-1:TAG_W];
        got.stamp = m_tdata[2*TAG_W+STAMP_W-1:2*TAG_W];
        got.last  = m_tlast;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: event %0d a_tag %0h b_tag %0h stamp %0h last %0b",
                     $time, got.ev, got.a_tag, got.b_tag, got.stamp, got.last);
            fail_count++;
        end else begin
            want = expected_q[0];
            expected_q.delete(0);
            if (got.ev !== want.ev)
                report_field("event", 64'(want.ev), 64'(got.ev));
            if (got.a_tag !== want.a_tag)
                report_field("a_tag", 64'(want.a_tag), 64'(got.a_tag));
            if (got.b_tag !== want.b_tag)
                report_field("b_tag", 64'(want.b_tag), 64'(got.b_tag));
            if (got.stamp !== want.stamp)
                report_field("pair_stamp", 64'(want.stamp), 64'(got.stamp));
            if (got.last !== want.last)
                report_field("tlast", 64'(want.last), 64'(got.last));
            if (want.ev == EV_PAIR)
                pairs_seen++;
            else
                discards_seen++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            a_cnt = 0;
            b_cnt = 0;
            tol_m = TOL_RESET;
            limit_m = LIMIT_RESET;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_TOLERANCE:   tol_m = cfg_data[TOL_W-1:0];
                    REG_QUEUE_LIMIT: limit_m = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_frame(s_tuser[0], s_tdata[STAMP_W-1:0],
                              s_tdata[STAMP_W+TAG_W-1:STAMP_W]);
                frames_seen++;
            end
            if (m_tvalid && m_tready)
                check_result();
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb_dual_stream_timestamp_matcher.sv =====
`timescale 1ns / 100ps

module tb_dual_stream_timestamp_matcher;
    import dstm_pkg::*;

    localparam int QD             = QUEUE_DEPTH_DEF;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 26;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // stamp, cloud_tag, pad
    logic [S_TUSER_W-1:0]   s_tuser = '0;   // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // a_tag, b_tag, pair_stamp, pad
    logic [M_TUSER_W-1:0]   m_tuser;        // event_res
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int frames_seen;
    int pairs_seen;
    int discards_seen;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_count = 0;
    int idle_cycles = 0;

    // random stream state
    logic [STAMP_W-1:0] cursor;
    logic [STAMP_W-1:0] last_stamp[2];
    logic [TOL_W-1:0]   tol_now;
    logic [TOL_W-1:0]   scale;
    int                 run_left = 0;
    logic               run_kind = 1'b0;

    dual_stream_timestamp_matcher #(
        .QUEUE_DEPTH(QD)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    dstm_match_checker #(
        .QUEUE_DEPTH(QD)
    ) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .frames_seen(frames_seen),
        .pairs_seen(pairs_seen), .discards_seen(discards_seen)
    );

    always #5 aclk = ~aclk;

    // result side: one long hold-off on request, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_req && hold_count < HOLD_CYCLES) begin
            m_tready = 1'b0;
            hold_count++;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
                $display("** dual_stream_timestamp_matcher: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_frame(input logic kind, input logic [STAMP_W-1:0] stamp,
                              input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {1'b0, tag, stamp};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        // a frame with no result may still be scanning queue B
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // mostly two streams walking forward in time, some stamps placed on the
    // tolerance edges of the other source, some arbitrary
    task automatic send_random_frame();
        logic               kind;
        logic [STAMP_W-1:0] stamp;
        logic [63:0]        step;
        int                 r;
        if (run_left > 0) begin
            kind = run_kind;
            run_left--;
        end else begin
            kind = 1'($urandom_range(1));
            if ($urandom_range(9) == 0) begin
                run_kind = kind;
                run_left = $urandom_range(20, 1);
            end
        end
        r = $urandom_range(99);
        if (r < 70) begin
            step = 64'($urandom_range(scale)) + 64'($urandom_range(scale));
            cursor = cursor + step[STAMP_W-1:0];
            stamp = cursor + STAMP_W'($urandom_range(scale));
        end else if (r < 85) begin
            case ($urandom_range(3))
                0: stamp = last_stamp[~kind];
                1: stamp = last_stamp[~kind] + STAMP_W'(tol_now);
                2: stamp = last_stamp[~kind] + STAMP_W'(tol_now) + STAMP_W'(1);
                default: stamp = last_stamp[~kind] - STAMP_W'(tol_now);
            endcase
        end else begin
            stamp = STAMP_W'({$urandom, $urandom});
        end
        last_stamp[kind] = stamp;
        send_frame(kind, stamp, TAG_W'($urandom));
    endtask

    initial begin
        logic [LIMIT_W-1:0] limit_now;
        for (int i = 0; i < 2; i++)
            last_stamp[i] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed frames on the reset settings
        send_frame(1'b0, 63'd1000, 16'h0000);
        send_frame(1'b1, 63'd2001000, 16'hFFFF);      // exactly on tolerance
        send_frame(1'b1, 63'd5000000, 16'h0001);
        send_frame(1'b0, 63'd0, 16'h0002);            // A head too old
        send_frame(1'b0, 63'd7000001, 16'h0003);      // B head too old
        send_frame(1'b1, 63'd10000000, 16'h0004);
        send_frame(1'b1, 63'd14000000, 16'h0005);
        send_frame(1'b0, 63'd12000000, 16'h0006);     // equal distance, earlier B wins
        send_frame(1'b0, STAMP_MAX, 16'hFFFF);
        send_frame(1'b1, STAMP_MAX, 16'h0007);
        for (int i = 0; i < 11; i++)                  // one past the limit
            send_frame(1'b1, 63'(20000000 + i * 1000000), 16'(16 + i));
        drain_results();
        // lower the limit on a queue at the old limit, next arrival evicts several
        write_reg(REG_QUEUE_LIMIT, 32'd3);
        send_frame(1'b1, 63'd40000000, 16'hA5A5);
        send_frame(1'b0, 63'd38500000, 16'h5A5A);
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin tol_now = 32'd2000000;  limit_now = 5'd10; end
                1: begin tol_now = 32'd0;        limit_now = 5'd16; end
                2: begin tol_now = 32'hFFFFFFFF; limit_now = 5'd1;  end
                3: begin tol_now = 32'd1000;     limit_now = 5'd31; end
                4: begin tol_now = 32'd500000;   limit_now = 5'd0;  end
                5: begin tol_now = 32'd123456789; limit_now = 5'd5; end
                6: begin tol_now = $urandom;     limit_now = 5'($urandom_range(16, 1)); end
                default: begin tol_now = 32'd2000000; limit_now = 5'd16; end
            endcase
            write_reg(REG_TOLERANCE, tol_now);
            write_reg(REG_QUEUE_LIMIT, 32'(limit_now));
            scale = (tol_now == 0) ? 32'd1000 : tol_now;
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin sender_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (phase == 5)
                cursor = STAMP_MAX - 63'd1000000000000;
            else if (phase == 7)
                cursor = '0;
            else
                cursor = STAMP_W'({$urandom, $urandom});
            last_stamp[0] = cursor;
            last_stamp[1] = cursor;
            run_left = 0;
            if (phase == 0) begin
                // result side blocks while frames keep coming
                @(posedge aclk);
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 2 && k == PHASE_ITEMS / 2)
                    drain_results();
                send_random_frame();
            end
            drain_results();
        end

        $display("run covered %0d frames giving %0d pairs and %0d discards", frames_seen,
                 pairs_seen, discards_seen);
        $display("over %0d tolerance/limit settings, incl. zero and full-scale tolerance",
                 NUM_PHASES + 2);
        if (fail_count == 0 && pending == 0) begin
            $display("** dual_stream_timestamp_matcher: PASSED **");
        end else begin
            $display("** dual_stream_timestamp_matcher: FAILED **");
        end
        $finish;
    end

endmodule
